[src/psh_pkg.sv]
// Shared types and constants for the position symbol histogram.
package psh_pkg;

   localparam int MAX_POSITIONS_DEF = 64;
   localparam int MAX_LETTERS_DEF   = 32;
   localparam int COUNT_WIDTH_DEF   = 32;
   localparam int TOTAL_WIDTH       = 32;
   localparam int FRAC_WIDTH        = 17;
   localparam int FRAC_BITS         = 16;

   typedef enum logic [1:0] {
      KIND_COUNT = 2'd0,
      KIND_FREQ  = 2'd1,
      KIND_PROB  = 2'd2,
      KIND_VERIFY = 2'd3
   } kind_type;

   localparam logic CSR_POSITIONS = 1'b0;
   localparam logic CSR_LETTERS   = 1'b1;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_UPDATE,
      ST_DIV,
      ST_VREAD,
      ST_VACC,
      ST_VCOL,
      ST_RESP
   } state_type;

   // Controller to datapath commands.
   typedef struct packed {
      logic load_item;   // capture request fields
      logic clear_wr;    // write zero at clear address
      logic clear_step;  // advance clear address
      logic rd_item;     // read counter at item address
      logic wr_incr;     // write incremented counter
      logic div_start;   // begin division
      logic div_step;    // one division step
      logic v_start;     // reset verify walk
      logic v_rd;        // read counter at walk address
      logic v_acc;       // accumulate read data
      logic v_col;       // close one column
      logic set_result;  // form the result for the item kind
      logic rsp_load;    // load output register
   } cmd_type;

   // Datapath to controller status.
   typedef struct packed {
      logic clear_done;
      logic range_bad;
      logic div_done;
      logic v_last_row;
      logic v_last_col;
      logic v_fail;
      logic total_zero;
   } status_type;

endpackage

[src/psh_ram.sv]
// Generic single-port RAM with registered read.
module psh_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata_ff <= mem[addr];
   end

   assign rdata = rdata_ff;
endmodule

[src/psh_ctrl.sv]
// Sequencer that clears the table after reset and steps each item through count, read, divide and verify.
module psh_ctrl
   import psh_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_fire,
   input  logic [1:0] req_kind,
   input  logic       rsp_busy,
   input  status_type status,
   output logic       req_ready,
   output cmd_type    cmd
);
   state_type state_ff, state_in;
   kind_type  kind_ff, kind_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         kind_ff  <= KIND_COUNT;
      end else begin
         state_ff <= state_in;
         kind_ff  <= kind_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      kind_in  = kind_ff;
      unique case (state_ff)
         ST_CLEAR: if (status.clear_done) state_in = ST_IDLE;
         ST_IDLE: begin
            if (req_fire) begin
               kind_in = kind_type'(req_kind);
               state_in = (kind_type'(req_kind) == KIND_VERIFY) ? ST_VREAD : ST_READ;
            end
         end
         ST_READ: begin
            if (status.range_bad) state_in = ST_RESP;
            else if (kind_ff == KIND_COUNT) state_in = ST_UPDATE;
            else if (kind_ff == KIND_PROB && !status.total_zero) state_in = ST_DIV;
            else state_in = ST_RESP;
         end
         ST_UPDATE: state_in = ST_RESP;
         ST_DIV: if (status.div_done) state_in = ST_RESP;
         ST_VREAD: state_in = ST_VACC;
         ST_VACC: state_in = status.v_last_row ? ST_VCOL : ST_VREAD;
         ST_VCOL: begin
            if (status.v_fail || status.v_last_col) state_in = ST_RESP;
            else state_in = ST_VREAD;
         end
         ST_RESP: if (!rsp_busy) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear_wr = 1'b1;
            cmd.clear_step = 1'b1;
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load_item = 1'b1;
            cmd.rd_item = 1'b1;
            cmd.v_start = 1'b1;
         end
         ST_READ: begin
            cmd.rd_item = 1'b1;
            cmd.div_start = 1'b1;
            cmd.set_result = 1'b1;
         end
         ST_UPDATE: cmd.wr_incr = 1'b1;
         ST_DIV: cmd.div_step = 1'b1;
         ST_VREAD: cmd.v_rd = 1'b1;
         ST_VACC: cmd.v_acc = 1'b1;
         ST_VCOL: cmd.v_col = 1'b1;
         ST_RESP: cmd.rsp_load = !rsp_busy;
         default: cmd = '0;
      endcase
   end
endmodule

[src/psh_dp.sv]
// Counter table, verify accumulator, divider and result register.
module psh_dp
   import psh_pkg::*;
#(
   parameter int MAX_POSITIONS = MAX_POSITIONS_DEF,
   parameter int MAX_LETTERS   = MAX_LETTERS_DEF,
   parameter int COUNT_WIDTH   = COUNT_WIDTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  cmd_type                cmd,
   input  logic [1:0]             req_kind,
   input  logic [4:0]             req_symbol,
   input  logic [5:0]             req_position,
   input  logic                   csr_we,
   input  logic                   csr_index,
   input  logic [6:0]             csr_data,
   input  logic                   rsp_tready,
   output logic                   rsp_tvalid,
   output logic [TOTAL_WIDTH-1:0] rsp_count,
   output logic [FRAC_WIDTH-1:0]  rsp_frac,
   output logic                   rsp_ok,
   output logic                   rsp_rerr,
   output logic                   rsp_busy,
   output status_type             status
);
   localparam int PW = (MAX_POSITIONS > 1) ? $clog2(MAX_POSITIONS) : 1;
   localparam int LW = $clog2(MAX_LETTERS);
   localparam int DEPTH = (1 << PW) * (1 << LW);
   localparam int AW = PW + LW;
   localparam logic [COUNT_WIDTH-1:0] CNT_FULL = '1;
   localparam logic [TOTAL_WIDTH:0] TOTAL_FULL = {1'b0, {TOTAL_WIDTH{1'b1}}};
   localparam int DW = TOTAL_WIDTH + FRAC_BITS + 1;
   localparam int DCW = $clog2(DW + 1);

   logic [6:0] npos_ff, npos_in;
   logic [5:0] nlet_ff, nlet_in;
   logic [1:0] kind_ff;
   logic [4:0] sym_ff;
   logic [5:0] pos_ff;
   logic [AW:0] clr_ff;
   logic [PW:0] vp_ff;
   logic [LW:0] vs_ff;
   logic [TOTAL_WIDTH:0] sum_ff;
   logic [TOTAL_WIDTH-1:0] common_ff, total_ff;
   logic [DW-1:0] rem_ff, quo_ff;
   logic [TOTAL_WIDTH-1:0] div_ff;
   logic [DCW-1:0] dcnt_ff;
   logic [TOTAL_WIDTH-1:0] cv_ff;
   logic [FRAC_WIDTH-1:0] fr_ff;
   logic ok_ff, rerr_ff, valid_ff;
   logic [TOTAL_WIDTH-1:0] out_cv_ff;
   logic [FRAC_WIDTH-1:0] out_fr_ff;
   logic out_ok_ff, out_rerr_ff;

   logic [6:0] act_pos;
   logic [8:0] act_let;
   logic walk_empty;
   logic we;
   logic [AW-1:0] addr;
   logic [COUNT_WIDTH-1:0] wdata, rdata;
   logic [TOTAL_WIDTH-1:0] rd_sat;
   logic [TOTAL_WIDTH:0] sum_next;
   logic range_bad;
   logic [TOTAL_WIDTH-1:0] num;

   function automatic logic [DW:0] next_rem();
      return {rem_ff, quo_ff[DW-1]};
   endfunction
   function automatic logic trial_next_neg();
      return next_rem() < (DW + 1)'(div_ff);
   endfunction

   assign npos_in = csr_data;
   assign nlet_in = csr_data[5:0];
   assign act_pos = (32'(npos_ff) > MAX_POSITIONS) ? 7'(MAX_POSITIONS) : npos_ff;
   assign act_let = (32'(nlet_ff) > MAX_LETTERS) ? 9'(MAX_LETTERS) : 9'(nlet_ff);
   assign range_bad = (9'(sym_ff) >= act_let) || (sym_ff >= MAX_LETTERS)
                      || (pos_ff >= act_pos) || (pos_ff >= MAX_POSITIONS);
   // With no active rows or no active columns every column sum is zero.
   assign walk_empty = (act_pos == '0) || (act_let == '0);

   always_comb begin
      we = 1'b0;
      wdata = '0;
      addr = AW'({LW'(sym_ff), PW'(pos_ff)});
      if (cmd.clear_wr) begin
         we = 1'b1;
         addr = clr_ff[AW-1:0];
      end else if (cmd.load_item) begin
         addr = AW'({LW'(req_symbol), PW'(req_position)});
      end else if (cmd.v_rd) begin
         addr = {vs_ff[LW-1:0], vp_ff[PW-1:0]};
      end else if (cmd.wr_incr) begin
         we = !range_bad && (rdata != CNT_FULL);
         wdata = rdata + 1'b1;
      end
   end

   psh_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(DEPTH)) u_ram (
      .clock(clock), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
   );

   // Counter clipped to the total width for summing.
   always_comb begin
      if (COUNT_WIDTH > TOTAL_WIDTH && (rdata >> TOTAL_WIDTH) != '0) begin
         rd_sat = '1;
      end else begin
         rd_sat = TOTAL_WIDTH'(rdata);
      end
   end
   always_comb begin
      sum_next = sum_ff + (TOTAL_WIDTH + 1)'(rd_sat);
      if (sum_next > TOTAL_FULL) sum_next = TOTAL_FULL;
   end

   assign num = (rd_sat > total_ff) ? total_ff : rd_sat;

   assign status.clear_done = (clr_ff == (AW + 1)'(DEPTH - 1));
   assign status.range_bad  = range_bad;
   assign status.div_done   = (dcnt_ff == DCW'(DW - 1));
   assign status.v_last_row = (9'(vs_ff) + 9'd1 >= act_let);
   assign status.v_last_col = (7'(vp_ff) + 7'd1 >= act_pos);
   assign status.v_fail     = (vp_ff != '0) && (TOTAL_WIDTH'(sum_ff) != common_ff);
   assign status.total_zero = (total_ff == '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         npos_ff <= 7'd64;
         nlet_ff <= 6'd4;
         clr_ff <= '0;
         total_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         if (csr_we && csr_index == CSR_POSITIONS) npos_ff <= npos_in;
         if (csr_we && csr_index == CSR_LETTERS) nlet_ff <= nlet_in;
         if (cmd.clear_step) clr_ff <= clr_ff + 1'b1;
         if (cmd.v_col && status.v_last_col && !status.v_fail) begin
            total_ff <= (vp_ff == '0) ? TOTAL_WIDTH'(sum_ff) : common_ff;
         end
         if (cmd.rsp_load) valid_ff <= 1'b1;
         else if (rsp_tready) valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         kind_ff <= req_kind;
         sym_ff <= req_symbol;
         pos_ff <= req_position;
      end
      if (cmd.v_start) begin
         vp_ff <= '0;
         vs_ff <= '0;
         sum_ff <= '0;
      end
      if (cmd.v_acc) begin
         sum_ff <= walk_empty ? '0 : sum_next;
         if (!status.v_last_row) vs_ff <= vs_ff + 1'b1;
      end
      if (cmd.v_col) begin
         if (vp_ff == '0) common_ff <= TOTAL_WIDTH'(sum_ff);
         vp_ff <= vp_ff + 1'b1;
         vs_ff <= '0;
         sum_ff <= '0;
      end
      if (cmd.div_start) begin
         rem_ff <= '0;
         quo_ff <= DW'({num, {FRAC_BITS{1'b0}}}) + DW'(total_ff >> 1);
         div_ff <= total_ff;
         dcnt_ff <= '0;
      end
      if (cmd.div_step) begin
         // Restoring division, one quotient bit a cycle.
         if (!trial_next_neg()) begin
            rem_ff <= DW'(next_rem() - (DW + 1)'(div_ff));
            quo_ff <= {quo_ff[DW-2:0], 1'b1};
         end else begin
            rem_ff <= DW'(next_rem());
            quo_ff <= {quo_ff[DW-2:0], 1'b0};
         end
         dcnt_ff <= dcnt_ff + 1'b1;
      end
      if (cmd.set_result) begin
         cv_ff <= '0;
         fr_ff <= '0;
         ok_ff <= 1'b0;
         rerr_ff <= range_bad;
         if (!range_bad && kind_type'(kind_ff) == KIND_FREQ) cv_ff <= TOTAL_WIDTH'(rdata);
         if (!range_bad && kind_type'(kind_ff) == KIND_PROB) ok_ff <= !status.total_zero;
      end
      if (cmd.v_col && (status.v_fail || status.v_last_col)) begin
         rerr_ff <= 1'b0;
         fr_ff <= '0;
         ok_ff <= !status.v_fail;
         cv_ff <= status.v_fail ? '0 : ((vp_ff == '0) ? TOTAL_WIDTH'(sum_ff) : common_ff);
      end
      if (cmd.div_step && status.div_done) begin
         fr_ff <= (({quo_ff[DW-2:0], !trial_next_neg()}) > DW'(1 << FRAC_BITS))
                  ? FRAC_WIDTH'(1 << FRAC_BITS)
                  : FRAC_WIDTH'({quo_ff[DW-2:0], !trial_next_neg()});
      end
      // The output register holds a waiting result while the next item runs.
      if (cmd.rsp_load) begin
         out_cv_ff <= cv_ff;
         out_fr_ff <= fr_ff;
         out_ok_ff <= ok_ff;
         out_rerr_ff <= rerr_ff;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_busy = valid_ff && !rsp_tready;
   assign rsp_count = out_cv_ff;
   assign rsp_frac = out_fr_ff;
   assign rsp_ok = out_ok_ff;
   assign rsp_rerr = out_rerr_ff;
endmodule

[src/position_symbol_histogram.sv]
// Top level of the position symbol histogram.
// A table of saturating counters, one per symbol and position. After reset a
// clearing pass writes every table entry once (the product of MAX_LETTERS and
// MAX_POSITIONS, each rounded up to a power of two, 2048 entries by default)
// before req_tready rises. Count, frequency and probability items go through
// one read of the single-port counter RAM: a count item writes the counter
// back incremented, a frequency item returns it, and a probability item with
// a nonzero total also goes through a bit-serial divider. Verify walks the
// active rows of every active column, reading then adding each counter, and
// stops early at the first unequal column. One item is in work at a time;
// req_tready rises again the cycle after the result is loaded into the output
// register. The output register lets the next item run while a result waits;
// a second finished result waits for it to drain.
module position_symbol_histogram
   import psh_pkg::*;
#(
   parameter int MAX_POSITIONS = MAX_POSITIONS_DEF,
   parameter int MAX_LETTERS   = MAX_LETTERS_DEF,
   parameter int COUNT_WIDTH   = COUNT_WIDTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // symbol[4:0], position[10:5], zero pad
   input  logic [1:0]  req_tuser,   // kind[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,   // count_value[31:0], fraction[48:32], ok, range_error
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [6:0]  csr_data
);
   cmd_type cmd;
   status_type status;
   logic rsp_busy;
   logic [TOTAL_WIDTH-1:0] count;
   logic [FRAC_WIDTH-1:0] frac;
   logic ok, rerr;
   logic [15:0] req_bits;

   // Packed fields: symbol in the low five bits, position in the next six.
   assign req_bits = req_tdata;

   psh_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .req_fire(req_tvalid && req_tready), .req_kind(req_tuser),
      .rsp_busy(rsp_busy), .status(status), .req_ready(req_tready), .cmd(cmd)
   );

   psh_dp #(
      .MAX_POSITIONS(MAX_POSITIONS), .MAX_LETTERS(MAX_LETTERS),
      .COUNT_WIDTH(COUNT_WIDTH)
   ) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .req_kind(req_tuser),
      .req_symbol(req_bits[4:0]), .req_position(req_bits[10:5]),
      .csr_we(csr_we), .csr_index(csr_index), .csr_data(csr_data),
      .rsp_tready(rsp_tready), .rsp_tvalid(rsp_tvalid), .rsp_count(count),
      .rsp_frac(frac), .rsp_ok(ok), .rsp_rerr(rerr), .rsp_busy(rsp_busy),
      .status(status)
   );

   assign rsp_tdata = {5'd0, rerr, ok, frac, count};
endmodule

[src/psh_checker.sv]
// Port-level checks on the histogram, bound to the top level.
module psh_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [55:0] rsp_tdata
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result dropped while stalled");
   a_one_at_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("accepted a second item while busy");
   a_frac_max: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[48:32] <= 17'd65536)
      else $error("fraction above one");
   a_err_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[50] |-> rsp_tdata[49:0] == '0)
      else $error("range error with payload");
endmodule

bind position_symbol_histogram psh_checker u_psh_checker (
   .clock(clock), .reset(reset), .req_tvalid(req_tvalid), .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
);

[tb/tb.sv]
// Self-checking testbench for the position symbol histogram.
`timescale 1ns / 100ps

module tb;
   import psh_pkg::*;

   localparam int NPOS_MAX   = 64;
   localparam int NLET_MAX   = 32;
   localparam int CYCLE_CAP  = 20000000;
   localparam int SHOW_LIMIT = 10;

   typedef struct {
      kind_type  kind;
      bit [4:0]  symbol;
      bit [5:0]  position;
   } query_type;

   typedef struct {
      bit [31:0] count_value;
      bit [16:0] fraction;
      bit        ok;
      bit        range_error;
   } answer_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   // Packed item fields from bit 0 up: symbol[4:0], position[10:5], zero pad.
   logic [15:0] req_tdata;
   // Item selector: kind[1:0].
   logic [1:0]  req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   // Result fields from bit 0 up: count_value[31:0], fraction[48:32], ok[49],
   // range_error[50], zero pad.
   logic [55:0] rsp_tdata;
   logic        csr_we;
   logic        csr_index;
   logic [6:0]  csr_data;

   position_symbol_histogram u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   // Shadow copy of the histogram that the predictor keeps in step with the
   // block, plus its two registers as last written.
   bit [31:0] shadow_counts [NLET_MAX][NPOS_MAX];
   bit [31:0] shadow_total;
   bit [6:0]  positions_reg;
   bit [5:0]  letters_reg;

   query_type  pending_items[$];
   answer_type expected_answers[$];
   query_type  offered;
   int        gap_left;
   int        stall_left;
   int        hold_left;
   bit        hold_done;
   int        answers_seen;
   int        mismatches;
   int        cycles;

   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 0;
   end

   function automatic int active_positions();
      return (positions_reg > NPOS_MAX) ? NPOS_MAX : int'(positions_reg);
   endfunction

   function automatic int active_letters();
      return (letters_reg > NLET_MAX) ? NLET_MAX : int'(letters_reg);
   endfunction

   // Works out the answer for one accepted item and updates the shadow table.
   function automatic answer_type histogram_answer(query_type q);
      answer_type a;
      bit [63:0] col_sum;
      bit [63:0] common;
      bit [63:0] total;
      bit [63:0] num;
      bit [63:0] frac;
      bit        equal;
      bit [31:0] c;
      a = '{default: 0};
      if (q.kind == KIND_VERIFY) begin
         equal  = 1'b1;
         common = 0;
         for (int p = 0; p < active_positions(); p++) begin
            col_sum = 0;
            for (int s = 0; s < active_letters(); s++) begin
               col_sum += shadow_counts[s][p];
               if (col_sum > 64'hFFFF_FFFF) col_sum = 64'hFFFF_FFFF;
            end
            if (p == 0) common = col_sum;
            else if (col_sum != common) equal = 1'b0;
         end
         if (equal) begin
            shadow_total  = common[31:0];
            a.ok          = 1'b1;
            a.count_value = common[31:0];
         end
      end else if (q.symbol >= active_letters() || q.position >= active_positions()) begin
         a.range_error = 1'b1;
      end else begin
         c = shadow_counts[q.symbol][q.position];
         case (q.kind)
            KIND_COUNT: begin
               if (c != 32'hFFFF_FFFF) shadow_counts[q.symbol][q.position] = c + 1;
            end
            KIND_FREQ: begin
               a.count_value = c;
            end
            default: begin
               if (shadow_total != 0) begin
                  total = shadow_total;
                  num   = (c > total) ? total : c;
                  frac  = ((num << 16) + (total >> 1)) / total;
                  if (frac > 65536) frac = 65536;
                  a.fraction = frac[16:0];
                  a.ok       = 1'b1;
               end
            end
         endcase
      end
      return a;
   endfunction

   // Driver: offers queued items with a random gap before each one.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
         req_tuser  <= KIND_COUNT;
         gap_left   <= $urandom_range(0, 8);
      end else if (!(req_tvalid && !req_tready)) begin
         // The slot is free: either nothing was offered or it was just taken.
         if (req_tvalid) expected_answers.push_back(histogram_answer(offered));
         if (gap_left > 0) begin
            gap_left   <= gap_left - 1;
            req_tvalid <= 1'b0;
         end else if (pending_items.size() > 0) begin
            offered = pending_items.pop_front();
            req_tvalid <= 1'b1;
            req_tdata  <= {5'b0, offered.position, offered.symbol};
            req_tuser  <= offered.kind;
            // At least a third of the items follow with no gap at all.
            gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 8);
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Monitor: checks each result against the oldest expectation and throttles
   // rsp_tready. Once, after a hundred results, the receiver holds off for a
   // long stretch while the driver keeps offering, so the input backs up.
   always @(posedge clock) begin
      answer_type want;
      answer_type got;
      if (reset) begin
         rsp_tready   <= 1'b0;
         stall_left   <= 0;
         hold_left    <= 0;
         hold_done    <= 1'b0;
         answers_seen <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.count_value = rsp_tdata[31:0];
            got.fraction    = rsp_tdata[48:32];
            got.ok          = rsp_tdata[49];
            got.range_error = rsp_tdata[50];
            answers_seen <= answers_seen + 1;
            if (expected_answers.size() == 0) begin
               mismatches++;
               if (mismatches <= SHOW_LIMIT)
                  $display("%0t: result with nothing expected: %p", $realtime, got);
            end else begin
               want = expected_answers.pop_front();
               if (got.count_value !== want.count_value || got.fraction !== want.fraction ||
                   got.ok !== want.ok || got.range_error !== want.range_error) begin
                  mismatches++;
                  if (mismatches <= SHOW_LIMIT)
                     $display("%0t: mismatch expected %p actual %p", $realtime, want, got);
               end
            end
         end
         if (!hold_done && answers_seen >= 100) begin
            hold_done  <= 1'b1;
            hold_left  <= 400;
            rsp_tready <= 1'b0;
         end else if (hold_left > 0) begin
            hold_left  <= hold_left - 1;
            rsp_tready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            if (rsp_tvalid && rsp_tready)
               stall_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 8);
         end
      end
   end

   // Watchdog on total run length.
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_CAP) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   task automatic push_item(kind_type k, int sym, int pos);
      query_type q;
      q.kind     = k;
      q.symbol   = sym[4:0];
      q.position = pos[5:0];
      pending_items.push_back(q);
   endtask

   task automatic wait_drained();
      do @(posedge clock);
      while (pending_items.size() != 0 || req_tvalid || expected_answers.size() != 0);
      // Every item gives one result, so the block is idle here; a short pause
      // anyway before touching the registers.
      repeat (10) @(posedge clock);
   endtask

   task automatic write_regs(int npos, int nlet);
      wait_drained();
      csr_we    <= 1'b1;
      csr_index <= CSR_POSITIONS;
      csr_data  <= npos[6:0];
      @(posedge clock);
      csr_index <= CSR_LETTERS;
      csr_data  <= nlet[6:0];
      @(posedge clock);
      csr_we    <= 1'b0;
      positions_reg = npos[6:0];
      letters_reg   = nlet[5:0];
   endtask

   // One aligned sequence: one count per active position. Now and then a
   // position is held back, a verify is issued on the uneven table, and the
   // missing count is added afterwards so the columns stay balanced.
   task automatic push_sequence();
      int np;
      int nl;
      int skip;
      np   = active_positions();
      nl   = active_letters();
      skip = ($urandom_range(0, 3) == 0 && np > 0) ? $urandom_range(0, np - 1) : -1;
      for (int p = 0; p < np; p++)
         if (p != skip) push_item(KIND_COUNT, $urandom_range(0, nl - 1), p);
      if (skip >= 0) begin
         push_item(KIND_VERIFY, $urandom_range(0, 31), $urandom_range(0, 63));
         push_item(KIND_COUNT, $urandom_range(0, nl - 1), skip);
      end
      push_item(KIND_VERIFY, $urandom_range(0, 31), $urandom_range(0, 63));
      repeat ($urandom_range(1, 4)) begin
         push_item($urandom_range(0, 1) ? KIND_FREQ : KIND_PROB,
                   $urandom_range(0, nl > 0 ? nl - 1 : 0),
                   $urandom_range(0, np > 0 ? np - 1 : 0));
      end
   endtask

   // Noise that never disturbs column balance: reads, probabilities and
   // verifies with any field values, and counts that fall outside the range.
   task automatic push_noise();
      int k;
      int sym;
      int pos;
      k   = $urandom_range(0, 3);
      sym = $urandom_range(0, 31);
      pos = $urandom_range(0, 63);
      if (k == KIND_COUNT) begin
         if (active_positions() < NPOS_MAX) pos = $urandom_range(active_positions(), 63);
         else if (active_letters() < NLET_MAX) sym = $urandom_range(active_letters(), 31);
         else k = KIND_FREQ;
      end
      push_item(kind_type'(k), sym, pos);
   endtask

   task automatic random_phase(int budget);
      int start;
      start = pending_items.size();
      while (pending_items.size() - start < budget) begin
         if ($urandom_range(0, 9) < 6) push_sequence();
         else repeat ($urandom_range(1, 6)) push_noise();
      end
   endtask

   // Stimulus. Registers move so that active positions never grow and active
   // letters never shrink after counting starts; that keeps equal columns
   // equal, so verify can keep passing across phases.
   initial begin
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = KIND_COUNT;
      rsp_tready = 1'b0;
      csr_we     = 1'b0;
      csr_index  = CSR_POSITIONS;
      csr_data   = '0;
      mismatches = 0;
      cycles     = 0;
      shadow_total  = 0;
      positions_reg = 7'd64;
      letters_reg   = 6'd4;
      foreach (shadow_counts[s, p]) shadow_counts[s][p] = 0;
      reset = 1'b1;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Empty table at reset settings: verify passes with a zero total, so a
      // probability still finds no total.
      push_item(KIND_VERIFY, 0, 0);
      push_item(KIND_PROB, 0, 0);
      push_item(KIND_FREQ, 3, 63);
      push_item(KIND_COUNT, 4, 0);
      push_item(KIND_COUNT, 31, 63);

      // Single letter: one full sequence gives total 1, a second count on
      // position 0 makes verify fail and pushes a counter above the total.
      write_regs(64, 1);
      for (int p = 0; p < 64; p++) push_item(KIND_COUNT, 0, p);
      push_item(KIND_VERIFY, 31, 63);
      push_item(KIND_PROB, 0, 5);
      push_item(KIND_FREQ, 0, 63);
      push_item(KIND_COUNT, 1, 0);
      push_item(KIND_COUNT, 0, 0);
      push_item(KIND_VERIFY, 0, 0);
      push_item(KIND_PROB, 0, 0);
      for (int p = 1; p < 64; p++) push_item(KIND_COUNT, 0, p);
      push_item(KIND_VERIFY, 0, 0);
      push_item(KIND_PROB, 0, 17);

      // Register values past the maximum clamp to the full table.
      write_regs(127, 63);
      random_phase(200);
      write_regs(40, 32);
      random_phase(160);
      write_regs(7, 32);
      random_phase(140);
      write_regs(1, 32);
      random_phase(80);
      // No active positions: verify passes with total 0, everything else
      // is out of range.
      write_regs(0, 32);
      random_phase(30);

      wait_drained();
      repeat (100) @(posedge clock);
      if (mismatches == 0 && expected_answers.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
